@@ rtl/core/i2c_register_access_sequencer_macros.svh @@
// assertion helpers used by the sequencer core rtl
`ifndef I2C_REGISTER_ACCESS_SEQUENCER_MACROS_SVH
`define I2C_REGISTER_ACCESS_SEQUENCER_MACROS_SVH

// same-cycle implication, held off during reset
`define I2CRAS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define I2CRAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/i2cras_pkg.sv @@
package i2cras_pkg;

   // input item (kind travels separately in tuser)
   typedef struct packed {
      logic       kind;
      logic [1:0] op;
      logic [6:0] dev_address;
      logic [7:0] reg_address;
      logic [7:0] write_value;
      logic [7:0] word_count;
      logic [7:0] bus_status;
      logic [7:0] rx_byte;
   } req_item_type;

   // result item
   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  tx_byte;
      logic        word_valid;
      logic [15:0] word_value;
      logic        done_res;
      logic [2:0]  final_status;
   } rsp_item_type;

   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 32;

   // item kinds
   localparam logic KIND_BEGIN = 1'b0;
   localparam logic KIND_EVENT = 1'b1;

   // operations
   localparam logic [1:0] OP_WRITE_BYTE = 2'd0;
   localparam logic [1:0] OP_READ_BYTE  = 2'd1;
   localparam logic [1:0] OP_READ_WORDS = 2'd2;
   localparam logic [1:0] OP_RESERVED   = 2'd3;

   // bus commands
   localparam logic [2:0] CMD_NONE    = 3'd0;
   localparam logic [2:0] CMD_START   = 3'd1;
   localparam logic [2:0] CMD_RSTART  = 3'd2;
   localparam logic [2:0] CMD_SEND    = 3'd3;
   localparam logic [2:0] CMD_RX_ACK  = 3'd4;
   localparam logic [2:0] CMD_RX_NACK = 3'd5;
   localparam logic [2:0] CMD_STOP    = 3'd6;

   // reported status
   localparam logic [2:0] FS_OK         = 3'd0;
   localparam logic [2:0] FS_ADDR_NACK_W = 3'd1;
   localparam logic [2:0] FS_DATA_NACK  = 3'd2;
   localparam logic [2:0] FS_ARB_LOST   = 3'd3;
   localparam logic [2:0] FS_ADDR_NACK_R = 3'd4;

   // controller status codes
   localparam logic [7:0] ST_MASK       = 8'hF8;
   localparam logic [7:0] ST_START      = 8'h08;
   localparam logic [7:0] ST_RSTART     = 8'h10;
   localparam logic [7:0] ST_ADDR_W_ACK = 8'h18;
   localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
   localparam logic [7:0] ST_DATA_ACK   = 8'h28;
   localparam logic [7:0] ST_DATA_NACK  = 8'h30;
   localparam logic [7:0] ST_ARB_LOST   = 8'h38;
   localparam logic [7:0] ST_ADDR_R_ACK = 8'h40;
   localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;

   // sequencer phases
   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_START  = 4'd1;
   localparam logic [3:0] PH_ADDR_W = 4'd2;
   localparam logic [3:0] PH_REG    = 4'd3;
   localparam logic [3:0] PH_DATA   = 4'd4;
   localparam logic [3:0] PH_RSTART = 4'd5;
   localparam logic [3:0] PH_ADDR_R = 4'd6;
   localparam logic [3:0] PH_RECV   = 4'd7;
   localparam logic [3:0] PH_STOP   = 4'd8;

endpackage

@@ rtl/core/i2c_register_access_sequencer.sv @@
// each accepted req beat passes the input reg, then the result reg, to become its rsp beat
// throughput: one beat per cycle unless rsp stalls; the step sits between both registers
// a stalled rsp side holds one result while one more req beat waits in the input reg
// reset: synchronous, active high; clears both valid flags and returns the sequencer to idle
// with all transaction state zeroed
module i2c_register_access_sequencer
   import i2cras_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // op[1:0], dev_address[8:2], reg_address[16:9], write_value[24:17],
   // word_count[32:25], bus_status[40:33], rx_byte[48:41], zero fill [55:49]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind: 0 begin transaction, 1 controller event
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // command[2:0], tx_byte[10:3], word_value[26:11], final_status[29:27], zero fill [31:30]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // word_valid[0], done_res[1]
   output logic [1:0]            rsp_tuser
);

   logic         item_valid;
   req_item_type item;
   rsp_item_type result;
   logic         load_ok;
   logic         advance;

   // an item moves into the result reg, and updates the state, in the same edge
   assign advance = item_valid && load_ok;

   i2cras_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // phase machine and transaction context
   i2cras_seq_core u_seq_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item),
      .result (result)
   );

   // result reg decouples the rsp side from the sequencer
   i2cras_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .result     (result),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ rtl/core/i2cras_in_stage.sv @@
module i2cras_in_stage
   import i2cras_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  advance,
   output logic                  item_valid,
   output req_item_type          item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.kind        <= req_tuser;
         item_ff.op          <= req_tdata[1:0];
         item_ff.dev_address <= req_tdata[8:2];
         item_ff.reg_address <= req_tdata[16:9];
         item_ff.write_value <= req_tdata[24:17];
         item_ff.word_count  <= req_tdata[32:25];
         item_ff.bus_status  <= req_tdata[40:33];
         item_ff.rx_byte     <= req_tdata[48:41];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ rtl/core/i2cras_seq_core.sv @@
`include "i2c_register_access_sequencer_macros.svh"

module i2cras_seq_core
   import i2cras_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [3:0] phase_ff,          phase_in;
   logic [1:0] cur_op_ff,         cur_op_in;
   logic [6:0] cur_device_ff,     cur_device_in;
   logic [7:0] cur_register_ff,   cur_register_in;
   logic [7:0] cur_write_byte_ff, cur_write_byte_in;
   logic [8:0] bytes_left_ff,     bytes_left_in;
   logic [7:0] low_byte_hold_ff,  low_byte_hold_in;
   logic [2:0] pending_ff,        pending_in;

   logic [7:0] st;
   logic [8:0] bl_dec;
   logic [8:0] bl_after;

   assign st     = item.bus_status & ST_MASK;
   assign bl_dec = bytes_left_ff - 9'd1;

   always_comb begin
      phase_in          = phase_ff;
      cur_op_in         = cur_op_ff;
      cur_device_in     = cur_device_ff;
      cur_register_in   = cur_register_ff;
      cur_write_byte_in = cur_write_byte_ff;
      bytes_left_in     = bytes_left_ff;
      low_byte_hold_in  = low_byte_hold_ff;
      pending_in        = pending_ff;
      bl_after          = bytes_left_ff;
      result            = '0;
      result.command    = CMD_NONE;
      result.final_status = FS_OK;

      if (item.kind == KIND_BEGIN) begin
         // begin only when idle and op is defined
         if (phase_ff == PH_IDLE && item.op != OP_RESERVED) begin
            cur_op_in         = item.op;
            cur_device_in     = item.dev_address;
            cur_register_in   = item.reg_address;
            cur_write_byte_in = item.write_value;
            low_byte_hold_in  = 8'h00;
            pending_in        = FS_OK;
            case (item.op)
               OP_READ_WORDS: bytes_left_in = {item.word_count, 1'b0};
               OP_READ_BYTE:  bytes_left_in = 9'd1;
               default:       bytes_left_in = 9'd0;
            endcase
            if (item.op == OP_READ_WORDS && item.word_count == 8'd0) begin
               // empty word read finishes without touching the bus
               result.done_res = 1'b1;
            end else begin
               result.command = CMD_START;
               phase_in       = PH_START;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_START: begin
               if (st == ST_START) begin
                  result.command = CMD_SEND;
                  result.tx_byte = {cur_device_ff, 1'b0};
                  phase_in       = PH_ADDR_W;
               end
            end
            PH_ADDR_W: begin
               if (st == ST_ADDR_W_ACK) begin
                  result.command = CMD_SEND;
                  result.tx_byte = cur_register_ff;
                  phase_in       = PH_REG;
               end else if (st == ST_ADDR_W_NACK) begin
                  result.command = CMD_STOP;
                  pending_in     = FS_ADDR_NACK_W;
                  phase_in       = PH_STOP;
               end else if (st == ST_ARB_LOST) begin
                  result.command = CMD_STOP;
                  pending_in     = FS_ARB_LOST;
                  phase_in       = PH_STOP;
               end
            end
            PH_REG: begin
               if (st == ST_DATA_ACK) begin
                  if (cur_op_ff == OP_WRITE_BYTE) begin
                     result.command = CMD_SEND;
                     result.tx_byte = cur_write_byte_ff;
                     phase_in       = PH_DATA;
                  end else begin
                     result.command = CMD_RSTART;
                     phase_in       = PH_RSTART;
                  end
               end else if (st == ST_DATA_NACK) begin
                  result.command = CMD_STOP;
                  pending_in     = FS_DATA_NACK;
                  phase_in       = PH_STOP;
               end else if (st == ST_ARB_LOST) begin
                  result.command = CMD_STOP;
                  pending_in     = FS_ARB_LOST;
                  phase_in       = PH_STOP;
               end
            end
            PH_DATA: begin
               if (st == ST_DATA_ACK) begin
                  result.command = CMD_STOP;
                  pending_in     = FS_OK;
                  phase_in       = PH_STOP;
               end else if (st == ST_DATA_NACK) begin
                  result.command = CMD_STOP;
                  pending_in     = FS_DATA_NACK;
                  phase_in       = PH_STOP;
               end else if (st == ST_ARB_LOST) begin
                  result.command = CMD_STOP;
                  pending_in     = FS_ARB_LOST;
                  phase_in       = PH_STOP;
               end
            end
            PH_RSTART: begin
               if (st == ST_RSTART) begin
                  result.command = CMD_SEND;
                  result.tx_byte = {cur_device_ff, 1'b1};
                  phase_in       = PH_ADDR_R;
               end
            end
            PH_ADDR_R: begin
               if (st == ST_ADDR_R_ACK) begin
                  result.command = (bytes_left_ff > 9'd1) ? CMD_RX_ACK : CMD_RX_NACK;
                  phase_in       = PH_RECV;
               end else if (st == ST_ADDR_R_NACK) begin
                  result.command = CMD_STOP;
                  pending_in     = FS_ADDR_NACK_R;
                  phase_in       = PH_STOP;
               end else if (st == ST_ARB_LOST) begin
                  result.command = CMD_STOP;
                  pending_in     = FS_ARB_LOST;
                  phase_in       = PH_STOP;
               end
            end
            PH_RECV: begin
               // status not checked while receiving
               if (cur_op_ff != OP_READ_WORDS) begin
                  result.word_valid = 1'b1;
                  result.word_value = {8'h00, item.rx_byte};
                  bl_after          = 9'd0;
               end else if (!bytes_left_ff[0]) begin
                  low_byte_hold_in = item.rx_byte;
                  bl_after         = bl_dec;
               end else begin
                  result.word_valid = 1'b1;
                  result.word_value = {item.rx_byte, low_byte_hold_ff};
                  bl_after          = bl_dec;
               end
               bytes_left_in = bl_after;
               if (bl_after == 9'd0) begin
                  result.command = CMD_STOP;
                  pending_in     = FS_OK;
                  phase_in       = PH_STOP;
               end else begin
                  result.command = (bl_after > 9'd1) ? CMD_RX_ACK : CMD_RX_NACK;
               end
            end
            PH_STOP: begin
               // any event after stop closes the transaction
               result.done_res     = 1'b1;
               result.final_status = pending_ff;
               phase_in            = PH_IDLE;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         cur_op_ff         <= OP_WRITE_BYTE;
         cur_device_ff     <= 7'd0;
         cur_register_ff   <= 8'd0;
         cur_write_byte_ff <= 8'd0;
         bytes_left_ff     <= 9'd0;
         low_byte_hold_ff  <= 8'd0;
         pending_ff        <= FS_OK;
      end else if (fire) begin
         phase_ff          <= phase_in;
         cur_op_ff         <= cur_op_in;
         cur_device_ff     <= cur_device_in;
         cur_register_ff   <= cur_register_in;
         cur_write_byte_ff <= cur_write_byte_in;
         bytes_left_ff     <= bytes_left_in;
         low_byte_hold_ff  <= low_byte_hold_in;
         pending_ff        <= pending_in;
      end
   end

   `I2CRAS_ASSERT_SAME(a_done_quiet, clock, reset, fire && result.done_res, result.command == CMD_NONE && !result.word_valid, "done beat carries a bus command or word")
   `I2CRAS_ASSERT_SAME(a_word_cmd, clock, reset, fire && result.word_valid, result.command == CMD_STOP || result.command == CMD_RX_ACK || result.command == CMD_RX_NACK, "word given out without receive or stop")
   `I2CRAS_ASSERT_NEXT(a_stop_phase, clock, reset, fire && result.command == CMD_STOP, phase_ff == PH_STOP, "stop issued but phase not stop")
   `I2CRAS_ASSERT_NEXT(a_busy_begin, clock, reset, fire && item.kind == KIND_BEGIN && phase_ff != PH_IDLE, $stable(phase_ff) && $stable(bytes_left_ff), "begin while busy changed state")

endmodule

@@ rtl/core/i2cras_out_stage.sv @@
module i2cras_out_stage
   import i2cras_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  rsp_item_type          result,
   output logic                  load_ok,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type data_ff;

   assign load_ok = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, data_ff.final_status, data_ff.word_value,
                        data_ff.tx_byte, data_ff.command};
   assign rsp_tuser  = {data_ff.done_res, data_ff.word_valid};

endmodule

@@ tb/sv/i2cras_transaction_checker.sv @@
`timescale 1ns / 100ps
module i2cras_transaction_checker
   import i2cras_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [1:0]            rsp_tuser,
   output int                    error_count,
   output int                    results_due,
   output bit                    sequencer_idle,
   output int                    req_beats,
   output int                    rsp_beats,
   output int                    words_seen,
   output int                    transfers_closed
);

   logic [3:0] phase;
   logic [1:0] cur_op;
   logic [6:0] cur_device;
   logic [7:0] cur_register;
   logic [7:0] cur_write_byte;
   logic [8:0] bytes_left;
   logic [7:0] low_byte_hold;
   logic [2:0] pending_status;

   rsp_item_type prediction;
   rsp_item_type outcomes_due[$];

   task begin_stop(input logic [2:0] status);
      pending_status = status;
      phase = PH_STOP;
      prediction.command = CMD_STOP;
   endtask

   // next bus command for one accepted beat
   task step_sequencer(input req_item_type it);
      logic [7:0] st;
      prediction = '0;
      st = it.bus_status & ST_MASK;
      if (it.kind == KIND_BEGIN) begin
         if (phase == PH_IDLE && it.op != OP_RESERVED) begin
            cur_op = it.op;
            cur_device = it.dev_address;
            cur_register = it.reg_address;
            cur_write_byte = it.write_value;
            if (it.op == OP_READ_WORDS)
               bytes_left = {it.word_count, 1'b0};
            else if (it.op == OP_READ_BYTE)
               bytes_left = 9'd1;
            else
               bytes_left = 9'd0;
            low_byte_hold = '0;
            pending_status = FS_OK;
            if (it.op == OP_READ_WORDS && it.word_count == 8'd0) begin
               prediction.done_res = 1'b1;
            end else begin
               prediction.command = CMD_START;
               phase = PH_START;
            end
         end
      end else begin
         case (phase)
            PH_START: begin
               if (st == ST_START) begin
                  prediction.command = CMD_SEND;
                  prediction.tx_byte = {cur_device, 1'b0};
                  phase = PH_ADDR_W;
               end
            end
            PH_ADDR_W: begin
               if (st == ST_ADDR_W_ACK) begin
                  prediction.command = CMD_SEND;
                  prediction.tx_byte = cur_register;
                  phase = PH_REG;
               end else if (st == ST_ADDR_W_NACK) begin
                  begin_stop(FS_ADDR_NACK_W);
               end else if (st == ST_ARB_LOST) begin
                  begin_stop(FS_ARB_LOST);
               end
            end
            PH_REG: begin
               if (st == ST_DATA_ACK) begin
                  if (cur_op == OP_WRITE_BYTE) begin
                     prediction.command = CMD_SEND;
                     prediction.tx_byte = cur_write_byte;
                     phase = PH_DATA;
                  end else begin
                     prediction.command = CMD_RSTART;
                     phase = PH_RSTART;
                  end
               end else if (st == ST_DATA_NACK) begin
                  begin_stop(FS_DATA_NACK);
               end else if (st == ST_ARB_LOST) begin
                  begin_stop(FS_ARB_LOST);
               end
            end
            PH_DATA: begin
               if (st == ST_DATA_ACK)
                  begin_stop(FS_OK);
               else if (st == ST_DATA_NACK)
                  begin_stop(FS_DATA_NACK);
               else if (st == ST_ARB_LOST)
                  begin_stop(FS_ARB_LOST);
            end
            PH_RSTART: begin
               if (st == ST_RSTART) begin
                  prediction.command = CMD_SEND;
                  prediction.tx_byte = {cur_device, 1'b1};
                  phase = PH_ADDR_R;
               end
            end
            PH_ADDR_R: begin
               if (st == ST_ADDR_R_ACK) begin
                  prediction.command = (bytes_left > 9'd1) ? CMD_RX_ACK : CMD_RX_NACK;
                  phase = PH_RECV;
               end else if (st == ST_ADDR_R_NACK) begin
                  begin_stop(FS_ADDR_NACK_R);
               end else if (st == ST_ARB_LOST) begin
                  begin_stop(FS_ARB_LOST);
               end
            end
            PH_RECV: begin
               // status is not looked at while bytes come in
               if (cur_op != OP_READ_WORDS) begin
                  prediction.word_valid = 1'b1;
                  prediction.word_value = {8'h00, it.rx_byte};
                  bytes_left = 9'd0;
               end else if (!bytes_left[0]) begin
                  low_byte_hold = it.rx_byte;
                  bytes_left = bytes_left - 9'd1;
               end else begin
                  prediction.word_valid = 1'b1;
                  prediction.word_value = {it.rx_byte, low_byte_hold};
                  bytes_left = bytes_left - 9'd1;
               end
               if (bytes_left == 9'd0)
                  begin_stop(FS_OK);
               else
                  prediction.command = (bytes_left > 9'd1) ? CMD_RX_ACK : CMD_RX_NACK;
            end
            PH_STOP: begin
               prediction.done_res = 1'b1;
               prediction.final_status = pending_status;
               phase = PH_IDLE;
            end
            default: ;
         endcase
      end
   endtask

   task check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      req_item_type item;
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         phase = PH_IDLE;
         cur_op = '0;
         cur_device = '0;
         cur_register = '0;
         cur_write_byte = '0;
         bytes_left = '0;
         low_byte_hold = '0;
         pending_status = '0;
         outcomes_due.delete();
         error_count = 0;
         results_due = 0;
         sequencer_idle = 1'b1;
         req_beats = 0;
         rsp_beats = 0;
         words_seen = 0;
         transfers_closed = 0;
      end else begin
         // compare first so a beat accepted now cannot match its own prediction
         if (rsp_tvalid && rsp_tready) begin
            rsp_beats++;
            got.command = rsp_tdata[2:0];
            got.tx_byte = rsp_tdata[10:3];
            got.word_value = rsp_tdata[26:11];
            got.final_status = rsp_tdata[29:27];
            got.word_valid = rsp_tuser[0];
            got.done_res = rsp_tuser[1];
            if (outcomes_due.size() == 0) begin
               $error("result beat with nothing expected, command %0d", got.command);
               error_count++;
            end else begin
               want = outcomes_due.pop_front();
               check_field("command", want.command, got.command);
               check_field("tx_byte", want.tx_byte, got.tx_byte);
               check_field("word_valid", want.word_valid, got.word_valid);
               check_field("word_value", want.word_value, got.word_value);
               check_field("done_res", want.done_res, got.done_res);
               check_field("final_status", want.final_status, got.final_status);
               if (want.word_valid)
                  words_seen++;
               if (want.done_res)
                  transfers_closed++;
            end
         end
         if (req_tvalid && req_tready) begin
            req_beats++;
            item.kind = req_tuser;
            item.op = req_tdata[1:0];
            item.dev_address = req_tdata[8:2];
            item.reg_address = req_tdata[16:9];
            item.write_value = req_tdata[24:17];
            item.word_count = req_tdata[32:25];
            item.bus_status = req_tdata[40:33];
            item.rx_byte = req_tdata[48:41];
            step_sequencer(item);
            outcomes_due.push_back(prediction);
         end
         results_due = outcomes_due.size();
         sequencer_idle = (phase == PH_IDLE);
      end
   end

endmodule

@@ tb/sv/i2c_register_access_sequencer_tb.sv @@
`timescale 1ns / 100ps
module i2c_register_access_sequencer_tb;
   import i2cras_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // op, dev_address, reg_address, write_value, word_count, bus_status, rx_byte, zero fill
   logic [REQ_DATA_W-1:0] req_tdata;
   // kind
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // command, tx_byte, word_value, final_status, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // word_valid, done_res
   logic [1:0]            rsp_tuser;

   int error_count;
   int results_due;
   bit sequencer_idle;
   int req_beats;
   int rsp_beats;
   int words_seen;
   int transfers_closed;

   // stimulus knobs; rsp_steady and hold_request are shared with the result-side process
   bit send_steady;
   bit rsp_steady;
   bit hold_request;
   bit noise_kind;
   int items_sent;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   i2c_register_access_sequencer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   i2cras_transaction_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .error_count      (error_count),
      .results_due      (results_due),
      .sequencer_idle   (sequencer_idle),
      .req_beats        (req_beats),
      .rsp_beats        (rsp_beats),
      .words_seen       (words_seen),
      .transfers_closed (transfers_closed)
   );

   // idle length: mostly none or short, now and then a long one
   function int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // controller event with every field random, status kept to multiples of eight
   function req_item_type random_item();
      req_item_type it;
      it.kind = KIND_EVENT;
      it.op = 2'($urandom_range(0, 2));
      it.dev_address = 7'($urandom);
      it.reg_address = 8'($urandom);
      it.write_value = 8'($urandom);
      it.word_count = 8'($urandom);
      it.bus_status = 8'($urandom_range(0, 31) << 3);
      it.rx_byte = 8'($urandom);
      return it;
   endfunction

   // one of the status codes the controller reports, or now and then 8'h00
   function logic [7:0] pick_code();
      case ($urandom_range(0, 9))
         0: return ST_START;
         1: return ST_RSTART;
         2: return ST_ADDR_W_ACK;
         3: return ST_ADDR_W_NACK;
         4: return ST_DATA_ACK;
         5: return ST_DATA_NACK;
         6: return ST_ARB_LOST;
         7: return ST_ADDR_R_ACK;
         8: return ST_ADDR_R_NACK;
         default: return 8'h00;
      endcase
   endfunction

   // offer one req beat; entered and left at a falling edge
   task push_request(input req_item_type it);
      int gap;
      gap = send_steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = it.kind;
      req_tdata = {7'b0, it.rx_byte, it.bus_status, it.word_count, it.write_value,
                   it.reg_address, it.dev_address, it.op};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
      // beat taken, nothing offered until the next call
      req_tvalid = 1'b0;
   endtask

   // controller completion, optionally preceded by a beat the sequencer must ignore
   task controller_event(input logic [7:0] st, input int noise_pct);
      req_item_type it;
      if ($urandom_range(0, 99) < noise_pct) begin
         it = random_item();
         if (noise_kind) begin
            // begin while a transaction is running
            it.kind = KIND_BEGIN;
            it.op = 2'($urandom_range(0, 3));
         end else begin
            // a code no waiting phase accepts
            it.bus_status = ($urandom_range(0, 3) == 0) ? 8'h00
                                                        : 8'($urandom_range(10, 31) << 3);
         end
         noise_kind = !noise_kind;
         push_request(it);
      end
      it = random_item();
      it.bus_status = st;
      push_request(it);
   endtask

   task bus_step(input logic [7:0] ok_code, input logic [7:0] nack_code, input bit fail,
                 input int noise_pct, output bit failed);
      failed = fail;
      if (fail)
         controller_event($urandom_range(0, 1) ? ST_ARB_LOST : nack_code, noise_pct);
      else
         controller_event(ok_code, noise_pct);
   endtask

   // well-formed transaction as a cooperative controller would answer it;
   // fault_step picks the address, register, data or read-address beat to refuse
   task run_transaction(input logic [1:0] op, input logic [6:0] dev, input logic [7:0] reg_a,
                        input logic [7:0] wval, input logic [7:0] wcount,
                        input int fault_step, input int noise_pct);
      req_item_type it;
      bit failed;
      int n_rx;
      it = random_item();
      it.kind = KIND_BEGIN;
      it.op = op;
      it.dev_address = dev;
      it.reg_address = reg_a;
      it.write_value = wval;
      it.word_count = wcount;
      push_request(it);
      // zero words: finished on the begin beat, no bus traffic
      if (op == OP_READ_WORDS && wcount == 8'd0)
         return;
      bus_step(ST_START, ST_START, 1'b0, noise_pct, failed);
      bus_step(ST_ADDR_W_ACK, ST_ADDR_W_NACK, fault_step == 1, noise_pct, failed);
      if (!failed)
         bus_step(ST_DATA_ACK, ST_DATA_NACK, fault_step == 2, noise_pct, failed);
      if (!failed && op == OP_WRITE_BYTE) begin
         bus_step(ST_DATA_ACK, ST_DATA_NACK, fault_step == 3, noise_pct, failed);
      end else if (!failed) begin
         bus_step(ST_RSTART, ST_RSTART, 1'b0, noise_pct, failed);
         bus_step(ST_ADDR_R_ACK, ST_ADDR_R_NACK, fault_step == 4, noise_pct, failed);
         if (!failed) begin
            // receive completions carry any status
            n_rx = (op == OP_READ_BYTE) ? 1 : 2 * wcount;
            repeat (n_rx) controller_event(8'($urandom_range(0, 31) << 3), 0);
         end
      end
      // stop completion, status does not matter
      controller_event(8'($urandom_range(0, 31) << 3), 0);
   endtask

   task wait_drained();
      while (results_due != 0) @(negedge clock);
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left == 0) begin
            if (hold_request) begin
               stall_left = 150;
               hold_request = 1'b0;
            end else if (!rsp_steady && $urandom_range(0, 2) == 0) begin
               stall_left = idle_gap();
            end
         end
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // run limit, well above the slowest legal run
   initial begin
      #(8_000_000);
      $display("timeout with %0d results still due", results_due);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      req_item_type it;
      int roll;
      int batches;
      logic [7:0] wc;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_BEGIN;
      send_steady = 1'b0;
      rsp_steady = 1'b0;
      hold_request = 1'b0;
      noise_kind = 1'b0;
      items_sent = 0;
      batches = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: write with top-end address, register and data
      run_transaction(OP_WRITE_BYTE, 7'h7F, 8'hFF, 8'hFF, 8'h00, 0, 0);
      // completion arriving with no transaction open
      it = random_item();
      it.bus_status = ST_START;
      push_request(it);
      // undefined operation
      it = random_item();
      it.kind = KIND_BEGIN;
      it.op = OP_RESERVED;
      push_request(it);
      // zero-length word read
      run_transaction(OP_READ_WORDS, 7'h2A, 8'h10, 8'h00, 8'h00, 0, 0);
      // single-byte read at the bottom of the ranges, every step up to the read address
      // preceded by a busy begin or an unexpected status in turn
      run_transaction(OP_READ_BYTE, 7'h00, 8'h00, 8'h00, 8'h00, 0, 100);
      wait_drained();

      // long result hold-off while the sender keeps going back to back
      hold_request = 1'b1;
      send_steady = 1'b1;
      run_transaction(OP_READ_WORDS, 7'($urandom), 8'($urandom), 8'($urandom), 8'd12, 0, 0);
      send_steady = 1'b0;
      // sender pauses until every result has come back
      wait_drained();

      // longest word run, once
      run_transaction(OP_READ_WORDS, 7'($urandom), 8'($urandom), 8'($urandom), 8'hFF, 0, 0);

      while (items_sent < 1100) begin
         send_steady = ($urandom_range(0, 4) == 0);
         rsp_steady = ($urandom_range(0, 4) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            // broken sequence: a begin, random codes, then random codes until back to idle
            it = random_item();
            it.kind = KIND_BEGIN;
            it.word_count = 8'($urandom_range(0, 3));
            push_request(it);
            repeat ($urandom_range(1, 6)) begin
               it = random_item();
               it.bus_status = pick_code();
               push_request(it);
            end
            while (!sequencer_idle) begin
               it = random_item();
               it.bus_status = pick_code();
               push_request(it);
            end
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
               wc = 8'd0;
            else if (roll < 85)
               wc = 8'($urandom_range(1, 4));
            else
               wc = 8'($urandom_range(5, 24));
            run_transaction(2'($urandom_range(0, 2)), 7'($urandom), 8'($urandom),
                            8'($urandom), wc,
                            ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 4),
                            ($urandom_range(0, 3) == 0) ? 25 : 0);
         end
         batches++;
         if (batches % 12 == 0)
            wait_drained();
         if (batches % 40 == 0)
            hold_request = 1'b1;
      end

      req_tvalid = 1'b0;
      send_steady = 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);

      $display("run covered %0d request beats and %0d result beats", req_beats, rsp_beats);
      $display("%0d words read back, %0d transactions closed, %0d mismatches",
               words_seen, transfers_closed, error_count);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
